>>> rtl/srdp_pkg.sv
// Shared types and constants for the sparse row dot product block.
`default_nettype none

package srdp_pkg;

  // Fixed field widths of the stream payloads
  localparam int KIND_W      = 2;
  localparam int FIELD_COL_W = 32;
  localparam int FIELD_VAL_W = 32;
  localparam int DOT_W       = 64;
  localparam int IN_DATA_W   = FIELD_COL_W + FIELD_VAL_W;

  // Defaults for the top-level parameters
  localparam int MAX_NONZEROS_DEF = 256;
  localparam int COLUMN_BITS_DEF  = 32;
  localparam int VALUE_BITS_DEF   = 32;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ROW = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_END_ROW
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [FIELD_COL_W-1:0] column;
    logic [FIELD_VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/srdp_front.sv
// Input front end: accepts transfers, decodes the kind and drops unused codes.
`default_nettype none

module srdp_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [srdp_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [srdp_pkg::KIND_W-1:0]    in_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output srdp_pkg::cmd_t                     q_cmd
);

  logic keep;

  always_comb begin
    q_cmd.column = in_tdata[srdp_pkg::FIELD_COL_W-1:0];
    q_cmd.value  = in_tdata[srdp_pkg::IN_DATA_W-1:srdp_pkg::FIELD_COL_W];
    q_cmd.op     = srdp_pkg::OP_LOAD_A;
    keep         = 1'b1;
    unique case (in_tuser)
      srdp_pkg::KIND_LOAD_A:  q_cmd.op = srdp_pkg::OP_LOAD_A;
      srdp_pkg::KIND_LOAD_B:  q_cmd.op = srdp_pkg::OP_LOAD_B;
      srdp_pkg::KIND_END_ROW: q_cmd.op = srdp_pkg::OP_END_ROW;
      default:                keep     = 1'b0;  // unused code: accept and drop
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

`default_nettype wire

>>> rtl/srdp_queue.sv
// Short command queue between the front end and the row engine.
`default_nettype none

module srdp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire srdp_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                pop_valid,
  output srdp_pkg::cmd_t      pop_cmd,
  input  wire logic           pop
);

  localparam int PTR_W = $clog2(srdp_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W:0] FULL_CNT = (PTR_W + 1)'(srdp_pkg::QUEUE_DEPTH);

  srdp_pkg::cmd_t    entry_r [srdp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W:0]    cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(srdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(srdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/srdp_back.sv
// Row engine: stores A and B entries and runs the merge walk at row end.
`default_nettype none

module srdp_back #(
  parameter int MAX_NONZEROS = srdp_pkg::MAX_NONZEROS_DEF,
  parameter int COLUMN_BITS  = srdp_pkg::COLUMN_BITS_DEF,
  parameter int VALUE_BITS   = srdp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire srdp_pkg::cmd_t              q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [srdp_pkg::DOT_W-1:0]       out_tdata,
  output logic                             out_tuser
);

  localparam int ADDR_W = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);
  localparam int PROD_W = 2 * VALUE_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NONZEROS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_EMIT
  } state_t;

  logic [COLUMN_BITS-1:0] a_col_mem [MAX_NONZEROS];
  logic [VALUE_BITS-1:0]  a_val_mem [MAX_NONZEROS];
  logic [COLUMN_BITS-1:0] b_col_mem [MAX_NONZEROS];
  logic [VALUE_BITS-1:0]  b_val_mem [MAX_NONZEROS];

  state_t                     state_r;
  logic [CNT_W-1:0]           a_cnt_r;
  logic [CNT_W-1:0]           b_cnt_r;
  logic                       dropped_r;
  logic [CNT_W-1:0]           i_r;
  logic [CNT_W-1:0]           j_r;
  logic [COLUMN_BITS-1:0]     a_col_rd_r;
  logic [VALUE_BITS-1:0]      a_val_rd_r;
  logic [COLUMN_BITS-1:0]     b_col_rd_r;
  logic [VALUE_BITS-1:0]      b_val_rd_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r;
  logic [srdp_pkg::DOT_W-1:0] sum_r;
  logic                       out_vld_r;
  logic [srdp_pkg::DOT_W-1:0] out_dot_r;
  logic                       out_flag_r;

  logic [COLUMN_BITS-1:0] in_col;
  logic [VALUE_BITS-1:0]  in_val;
  logic                   wr_a;
  logic                   wr_b;
  logic                   rd_en;

  assign in_col = COLUMN_BITS'(q_cmd.column);
  assign in_val = VALUE_BITS'(q_cmd.value);
  assign q_pop  = q_valid && (state_r == ST_IDLE);
  assign wr_a   = q_pop && (q_cmd.op == srdp_pkg::OP_LOAD_A) && (a_cnt_r != MAX_CNT);
  assign wr_b   = q_pop && (q_cmd.op == srdp_pkg::OP_LOAD_B) && (b_cnt_r != MAX_CNT);
  assign rd_en  = (state_r == ST_WALK_RD);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dot_r;
  assign out_tuser  = out_flag_r;

  // Entry buffers: one write and one registered read per side
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_col_mem[a_cnt_r[ADDR_W-1:0]] <= in_col;
      a_val_mem[a_cnt_r[ADDR_W-1:0]] <= in_val;
    end
    if (wr_b) begin
      b_col_mem[b_cnt_r[ADDR_W-1:0]] <= in_col;
      b_val_mem[b_cnt_r[ADDR_W-1:0]] <= in_val;
    end
    if (rd_en) begin
      a_col_rd_r <= a_col_mem[i_r[ADDR_W-1:0]];
      a_val_rd_r <= a_val_mem[i_r[ADDR_W-1:0]];
      b_col_rd_r <= b_col_mem[j_r[ADDR_W-1:0]];
      b_val_rd_r <= b_val_mem[j_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      a_cnt_r    <= '0;
      b_cnt_r    <= '0;
      dropped_r  <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      // The emit state owns the valid in its own cycles
      if (out_vld_r && out_tready && (state_r != ST_EMIT)) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_cmd.op)
              srdp_pkg::OP_LOAD_A: begin
                if (a_cnt_r == MAX_CNT) dropped_r <= 1'b1;
                else                    a_cnt_r   <= a_cnt_r + 1'b1;
              end
              srdp_pkg::OP_LOAD_B: begin
                if (b_cnt_r == MAX_CNT) dropped_r <= 1'b1;
                else                    b_cnt_r   <= b_cnt_r + 1'b1;
              end
              srdp_pkg::OP_END_ROW: begin
                i_r        <= '0;
                j_r        <= '0;
                sum_r      <= '0;
                prod_vld_r <= 1'b0;
                state_r    <= ST_WALK_RD;
              end
              default: ;
            endcase
          end
        end
        ST_WALK_RD: begin
          // Fold in the product from the previous match, then read or finish
          if (prod_vld_r) begin
            sum_r <= sum_r + srdp_pkg::DOT_W'(prod_r);
          end
          prod_vld_r <= 1'b0;
          if ((i_r < a_cnt_r) && (j_r < b_cnt_r)) state_r <= ST_WALK_CMP;
          else                                    state_r <= ST_EMIT;
        end
        ST_WALK_CMP: begin
          if (a_col_rd_r < b_col_rd_r) begin
            i_r <= i_r + 1'b1;
          end else if (a_col_rd_r > b_col_rd_r) begin
            j_r <= j_r + 1'b1;
          end else begin
            prod_r     <= signed'(a_val_rd_r) * signed'(b_val_rd_r);
            prod_vld_r <= 1'b1;
            i_r        <= i_r + 1'b1;
            j_r        <= j_r + 1'b1;
          end
          state_r <= ST_WALK_RD;
        end
        ST_EMIT: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r  <= 1'b1;
            out_dot_r  <= sum_r;
            out_flag_r <= dropped_r;
            a_cnt_r    <= '0;
            b_cnt_r    <= '0;
            dropped_r  <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sparse_row_dot_product.sv
// Result path: an end-of-row transfer leaves the queue and moves the row engine from idle
//   through S merge steps, at most a_count + b_count - 1 and none when a side is empty,
//   each a registered buffer read state then a column compare state, then to the emit state.
// Throughput: one load per cycle while the row engine is idle; loads wait in the queue
//   while a row is walked, and the emit state waits for the output register to be free.
// Reset: synchronous, active low; clears the queue, both entry counts, the dropped flag and
//   the output valid. Entry buffers are not cleared and need no clearing pass.
`default_nettype none

module sparse_row_dot_product #(
  parameter int MAX_NONZEROS = srdp_pkg::MAX_NONZEROS_DEF,
  parameter int COLUMN_BITS  = srdp_pkg::COLUMN_BITS_DEF,
  parameter int VALUE_BITS   = srdp_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [srdp_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] column, [63:32] value
  input  wire logic [srdp_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [srdp_pkg::DOT_W-1:0]           out_tdata,  // [63:0] dot
  output logic                                 out_tuser   // [0] overflowed
);

  // Front end to queue
  logic           q_push;
  logic           q_full;
  srdp_pkg::cmd_t q_push_cmd;

  // Queue to row engine
  logic           q_valid;
  logic           q_pop;
  srdp_pkg::cmd_t q_cmd;

  // Decode the kind and push loads and row ends; unused kinds transfer and drop
  srdp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // Hold commands while the engine walks a row, so loads of the next row keep flowing
  srdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd),
    .pop       (q_pop)
  );

  // Store entries, walk both buffers in load order, and emit through an output register
  srdp_back #(
    .MAX_NONZEROS (MAX_NONZEROS),
    .COLUMN_BITS  (COLUMN_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the sparse row dot product block.
`default_nettype none

typedef struct {
  logic [1:0]  kind;
  logic [31:0] column;
  logic [31:0] value;
} stream_item_t;

typedef struct {
  logic [63:0] dot;
  logic        overflowed;
} row_result_t;

class dot_scoreboard;
  localparam int DEPTH = srdp_pkg::MAX_NONZEROS_DEF;

  logic [31:0] a_cols[DEPTH];
  int          a_vals[DEPTH];
  logic [31:0] b_cols[DEPTH];
  int          b_vals[DEPTH];
  int          a_fill;
  int          b_fill;
  bit          row_dropped;
  row_result_t pending_dots[$];
  int          errors;

  function new();
    a_fill      = 0;
    b_fill      = 0;
    row_dropped = 1'b0;
    errors      = 0;
  endfunction

  function int pending();
    return pending_dots.size();
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Merge walk over both buffers in load order, 64-bit wrapping sum.
  function logic [63:0] compute_row_dot();
    int     i;
    int     j;
    longint sum;
    i   = 0;
    j   = 0;
    sum = 0;
    while (i < a_fill && j < b_fill) begin
      if (a_cols[i] < b_cols[j]) begin
        i++;
      end else if (a_cols[i] > b_cols[j]) begin
        j++;
      end else begin
        sum = sum + longint'(a_vals[i]) * longint'(b_vals[j]);
        i++;
        j++;
      end
    end
    return sum;
  endfunction

  // Note one accepted input transfer and, for a row end, queue the result it causes.
  function void note_transfer(stream_item_t item);
    row_result_t res;
    case (item.kind)
      srdp_pkg::KIND_LOAD_A: begin
        if (a_fill >= DEPTH) begin
          row_dropped = 1'b1;
        end else begin
          a_cols[a_fill] = item.column;
          a_vals[a_fill] = item.value;
          a_fill++;
        end
      end
      srdp_pkg::KIND_LOAD_B: begin
        if (b_fill >= DEPTH) begin
          row_dropped = 1'b1;
        end else begin
          b_cols[b_fill] = item.column;
          b_vals[b_fill] = item.value;
          b_fill++;
        end
      end
      srdp_pkg::KIND_END_ROW: begin
        res.dot        = compute_row_dot();
        res.overflowed = row_dropped;
        pending_dots.push_back(res);
        a_fill      = 0;
        b_fill      = 0;
        row_dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task check_result(logic [63:0] dot, logic overflowed);
    row_result_t exp_res;
    if (pending_dots.size() == 0) begin
      report_mismatch($sformatf("unexpected result dot=%h overflowed=%b", dot, overflowed));
    end else begin
      exp_res = pending_dots.pop_front();
      if (dot !== exp_res.dot)
        report_mismatch($sformatf("dot got %h expected %h", dot, exp_res.dot));
      if (overflowed !== exp_res.overflowed)
        report_mismatch($sformatf("overflowed got %b expected %b",
                                  overflowed, exp_res.overflowed));
    end
  endtask
endclass

module tb;
  import srdp_pkg::*;

  localparam int                MAX_NZ       = MAX_NONZEROS_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam int                RANDOM_ITEMS = 190;
  localparam int                IDLE_PCT     = 37;
  // Longest merge walk is one step per stored entry on both sides.
  localparam int                DRAIN_CYCLES = 2 * (2 * MAX_NZ) + 8;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;  // [31:0] column, [63:32] value
  logic [KIND_W-1:0]    in_tuser   = '0;  // [1:0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DOT_W-1:0]     out_tdata;        // [63:0] dot
  logic                 out_tuser;        // [0] overflowed

  dot_scoreboard sb = new();

  bit in_idle_on   = 1'b1;
  bit out_idle_on  = 1'b1;
  int hold_left    = 0;
  int random_items = 0;

  sparse_row_dot_product dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Result side: check every transfer, then pick next cycle's ready. A long hold-off,
  // when requested, wins over random idling.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_tready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the transfer happens; keep valid high into the
  // next item unless a random gap is taken.
  task automatic send_item(logic [1:0] kind, logic [31:0] column, logic [31:0] value);
    stream_item_t item;
    item.kind   = kind;
    item.column = column;
    item.value  = value;
    if (in_idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {value, column};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(item);
  endtask

  // Drop valid and hold until every queued result has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One row: ascending columns from a shared base so the sides intersect often.
  // A few rows get scrambled columns, and ignored items are sprinkled in as noise.
  task automatic send_random_row(int max_len);
    int          na;
    int          nb;
    int          ia;
    int          ib;
    bit          scrambled;
    logic [31:0] ca;
    logic [31:0] cb;
    na        = $urandom_range(0, max_len);
    nb        = $urandom_range(0, max_len);
    ia        = 0;
    ib        = 0;
    scrambled = ($urandom_range(0, 99) < 12);
    ca        = $urandom_range(0, 32'hFFFF_FF00);
    cb        = ca;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 99) < 5)
        send_item(KIND_UNUSED, $urandom, $urandom);
      if (ia < na && (ib >= nb || $urandom_range(0, 1) == 0)) begin
        send_item(KIND_LOAD_A, scrambled ? $urandom : ca, pick_value());
        ca = ca + $urandom_range(1, 3);
        ia++;
      end else begin
        send_item(KIND_LOAD_B, scrambled ? $urandom : cb, pick_value());
        cb = cb + $urandom_range(1, 3);
        ib++;
      end
      random_items++;
    end
    send_item(KIND_END_ROW, $urandom, $urandom);
    random_items++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty row gives zero.
    send_item(KIND_END_ROW, 32'h0, 32'h0);
    // Extreme columns and values: max times min plus min times min.
    send_item(KIND_LOAD_A, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_B, 32'h0000_0000, 32'h8000_0000);
    send_item(KIND_LOAD_A, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(KIND_LOAD_B, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(KIND_END_ROW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Unused kind must leave the row untouched.
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_LOAD_A, 32'd5, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 32'd5, 32'h1234_5678);
    send_item(KIND_LOAD_B, 32'd5, 32'hFFFF_FFFF);
    send_item(KIND_END_ROW, 32'd0, 32'd0);
    // Disjoint columns give zero.
    send_item(KIND_LOAD_A, 32'd1, 32'd3);
    send_item(KIND_LOAD_A, 32'd3, 32'd5);
    send_item(KIND_LOAD_B, 32'd2, 32'd7);
    send_item(KIND_LOAD_B, 32'd4, 32'd9);
    send_item(KIND_END_ROW, 32'd0, 32'd0);
    // Columns out of order: the walk follows load order with no check.
    send_item(KIND_LOAD_A, 32'd10, 32'd2);
    send_item(KIND_LOAD_A, 32'd4, 32'd3);
    send_item(KIND_LOAD_B, 32'd4, 32'd5);
    send_item(KIND_LOAD_B, 32'd10, 32'd7);
    send_item(KIND_END_ROW, 32'd0, 32'd0);
    // Repeated column on one side.
    send_item(KIND_LOAD_A, 32'd7, 32'd2);
    send_item(KIND_LOAD_A, 32'd7, 32'd3);
    send_item(KIND_LOAD_B, 32'd7, 32'd4);
    send_item(KIND_END_ROW, 32'd0, 32'd0);

    // Buffer full on side A: the extra loads drop and flag the row. Side B gets a
    // sparse set of matching columns.
    for (int k = 0; k < MAX_NZ + 2; k++) begin
      send_item(KIND_LOAD_A, k, pick_value());
      if (k % 8 == 0)
        send_item(KIND_LOAD_B, 2 * k, pick_value());
    end
    send_item(KIND_END_ROW, 32'd0, 32'd0);
    // Next row must start clean.
    send_item(KIND_LOAD_A, 32'd1, 32'd1);
    send_item(KIND_LOAD_B, 32'd1, 32'd1);
    send_item(KIND_END_ROW, 32'd0, 32'd0);

    // Stretch with both sides running flat out.
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    while (random_items < 80) send_random_row(10);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    // Hold the result side off while short rows keep coming, so the queue fills
    // and the input stalls.
    hold_left = 300;
    for (int r = 0; r < 12; r++) send_random_row(1);
    wait_drained();

    while (random_items < RANDOM_ITEMS) send_random_row(10);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sparse_row_dot_product test passed");
    end else begin
      $display("sparse_row_dot_product test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(4 * 400000);
    $display("sparse_row_dot_product test failed");
    $finish;
  end

endmodule

`default_nettype wire
